/* design/tmrht_pkg.sv */
// shared types and constants for the tile map region hit test
package tmrht_pkg;

  localparam int DEF_MAX_COLS  = 128;
  localparam int DEF_MAX_ROWS  = 128;
  localparam int DEF_TILE_SIZE = 64;

  localparam int CODE_W  = 12;
  localparam int TCOL_W  = 7;
  localparam int TROW_W  = 7;
  localparam int POS_W   = 16;
  localparam int SIZE_W  = 15;
  localparam int CFG_DW  = 8;
  localparam int CFG_IW  = 1;

  localparam logic [CFG_IW-1:0] REG_MAP_COLS = 1'b0;
  localparam logic [CFG_IW-1:0] REG_MAP_ROWS = 1'b1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    DIV_LEFT   = 2'd0,
    DIV_TOP    = 2'd1,
    DIV_RIGHT  = 2'd2,
    DIV_BOTTOM = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     clip;
    logic     div;
    div_sel_t div_sel;
    logic     scan_init;
    logic     scan_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic hit;
    logic out_busy;
  } sts_t;

endpackage

/* design/tmrht_ram.sv */
// generic single write port, single read port ram with registered read
module tmrht_ram #(
  parameter int WIDTH  = 12,
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/tmrht_ctrl.sv */
// sequencing state machine for write and query words
module tmrht_ctrl
  import tmrht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLIP   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_SETUP  = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    cmd           = '0;
    cmd.div_sel   = div_sel_t'(div_cnt_r);
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_kind == KIND_QUERY) ? S_CLIP : S_FINISH;
        end
      end
      S_CLIP: begin
        cmd.clip    = 1'b1;
        div_cnt_nxt = 2'd0;
        state_nxt   = sts.empty ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        cmd.div     = 1'b1;
        div_cnt_nxt = div_cnt_r + 2'd1;
        if (div_cnt_r == 2'd3) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the previous word finished");

  a_query_runs_divider: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_init |-> $past(cmd.div) && $past(cmd.div_sel) == DIV_BOTTOM)
    else $error("tile scan started without a full set of tile bounds");
`endif

endmodule

/* design/tmrht_dp.sv */
// clipping, tile bound divider, tile scan, tile store and output register
module tmrht_dp
  import tmrht_pkg::*;
#(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int TILE_SIZE = DEF_TILE_SIZE
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_kind,
  input  logic [TCOL_W-1:0]        in_tile_col,
  input  logic [TROW_W-1:0]        in_tile_row,
  input  logic [CODE_W-1:0]        in_tile_code,
  input  logic signed [POS_W-1:0]  in_rect_x,
  input  logic signed [POS_W-1:0]  in_rect_y,
  input  logic [SIZE_W-1:0]        in_rect_w,
  input  logic [SIZE_W-1:0]        in_rect_h,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  input  logic                     cfg_valid,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [CFG_DW-1:0]        cfg_wdata,
  input  cmd_t                     cmd,
  output sts_t                     sts
);

  localparam int DIM_MAX = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int PIX_MAX = DIM_MAX * TILE_SIZE;
  localparam int PW      = $clog2(PIX_MAX + 1);
  localparam int CW      = (PW + 1 > 18) ? PW + 1 : 18;
  localparam int QW      = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int EW      = ($clog2(DIM_MAX + 1) > CFG_DW) ? $clog2(DIM_MAX + 1) : CFG_DW;
  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TL      = $clog2(TILE_SIZE);
  localparam int MUL_S   = PW + TL;
  localparam longint MUL_K = ((longint'(1) << MUL_S) + longint'(TILE_SIZE) - 1)
                             / longint'(TILE_SIZE);
  localparam int KW      = $clog2(MUL_K + 1);
  localparam int MW0     = PW + KW;
  localparam int MW1     = MUL_S + QW;
  localparam int MW      = (MW0 > MW1) ? MW0 : MW1;

  // configuration
  logic [CFG_DW-1:0] map_cols_r, map_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_cols_r <= CFG_DW'(1);
      map_rows_r <= CFG_DW'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_MAP_COLS) begin
        map_cols_r <= cfg_wdata;
      end
      if (cfg_index == REG_MAP_ROWS) begin
        map_rows_r <= cfg_wdata;
      end
    end
  end

  logic [EW-1:0] cols_ext, rows_ext, cols_eff, rows_eff;
  logic [PW-1:0] mr_u, mb_u;

  assign cols_ext = EW'(map_cols_r);
  assign rows_ext = EW'(map_rows_r);
  assign cols_eff = (map_cols_r == '0) ? EW'(1) :
                    ((cols_ext > EW'(MAX_COLS)) ? EW'(MAX_COLS) : cols_ext);
  assign rows_eff = (map_rows_r == '0) ? EW'(1) :
                    ((rows_ext > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : rows_ext);
  assign mr_u = PW'(cols_eff) * PW'(TILE_SIZE);
  assign mb_u = PW'(rows_eff) * PW'(TILE_SIZE);

  // latched word
  logic signed [POS_W-1:0] x_r, y_r;
  logic [SIZE_W-1:0]       w_r, h_r;
  logic [CODE_W-1:0]       code_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_rect_x;
      y_r    <= in_rect_y;
      w_r    <= in_rect_w;
      h_r    <= in_rect_h;
      code_r <= in_tile_code;
    end
  end

  // tile store write on accept
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  assign wr_en   = cmd.load && (in_kind == KIND_WRITE) &&
                   (32'(in_tile_col) < 32'(MAX_COLS)) &&
                   (32'(in_tile_row) < 32'(MAX_ROWS));
  assign wr_addr = AW'(in_tile_row) * AW'(MAX_COLS) + AW'(in_tile_col);

  // clipping
  logic signed [CW-1:0] xe, ye, rgt_raw, bot_raw, mr_s, mb_s;
  logic signed [CW-1:0] lft, tp, rgt, bot, rgt_m1, bot_m1;

  assign xe      = $signed({{(CW-POS_W){x_r[POS_W-1]}}, x_r});
  assign ye      = $signed({{(CW-POS_W){y_r[POS_W-1]}}, y_r});
  assign rgt_raw = xe + $signed({{(CW-SIZE_W){1'b0}}, w_r});
  assign bot_raw = ye + $signed({{(CW-SIZE_W){1'b0}}, h_r});
  assign mr_s    = $signed({{(CW-PW){1'b0}}, mr_u});
  assign mb_s    = $signed({{(CW-PW){1'b0}}, mb_u});
  assign lft     = (xe < 0) ? '0 : xe;
  assign tp      = (ye < 0) ? '0 : ye;
  assign rgt     = (rgt_raw > mr_s) ? mr_s : rgt_raw;
  assign bot     = (bot_raw > mb_s) ? mb_s : bot_raw;
  assign rgt_m1  = rgt - CW'(1);
  assign bot_m1  = bot - CW'(1);

  logic [PW-1:0] left_r, top_r, rm1_r, bm1_r;

  always_ff @(posedge clk) begin
    if (cmd.clip) begin
      left_r <= lft[PW-1:0];
      top_r  <= tp[PW-1:0];
      rm1_r  <= rgt_m1[PW-1:0];
      bm1_r  <= bot_m1[PW-1:0];
    end
  end

  // pixel to tile divider, one bound per cycle by reciprocal multiply
  logic [PW-1:0] div_op;
  logic [MW-1:0] div_prod;
  logic [QW-1:0] div_quo;
  logic [QW-1:0] sx_r, sy_r, ex_r, ey_r;

  always_comb begin
    case (cmd.div_sel)
      DIV_LEFT:   div_op = left_r;
      DIV_TOP:    div_op = top_r;
      DIV_RIGHT:  div_op = rm1_r;
      DIV_BOTTOM: div_op = bm1_r;
      default:    div_op = left_r;
    endcase
  end

  assign div_prod = MW'(div_op) * MW'(MUL_K);
  assign div_quo  = div_prod[MUL_S +: QW];

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      case (cmd.div_sel)
        DIV_LEFT:   sx_r <= div_quo;
        DIV_TOP:    sy_r <= div_quo;
        DIV_RIGHT:  ex_r <= div_quo;
        DIV_BOTTOM: ey_r <= div_quo;
        default:    sx_r <= div_quo;
      endcase
    end
  end

  // tile scan
  logic [QW-1:0] cx_r, cy_r;
  logic [AW-1:0] addr_r, rbase_r, rbase_init, rbase_next;
  logic          row_end;

  assign rbase_init = AW'(sy_r) * AW'(MAX_COLS);
  assign rbase_next = rbase_r + AW'(MAX_COLS);
  assign row_end    = (cx_r == ex_r);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cx_r    <= sx_r;
      cy_r    <= sy_r;
      rbase_r <= rbase_init;
      addr_r  <= rbase_init + AW'(sx_r);
    end else if (cmd.scan_step) begin
      if (row_end) begin
        cx_r    <= sx_r;
        cy_r    <= cy_r + QW'(1);
        rbase_r <= rbase_next;
        addr_r  <= rbase_next + AW'(sx_r);
      end else begin
        cx_r   <= cx_r + QW'(1);
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  logic [CODE_W-1:0] rd_data;

  tmrht_ram #(
    .WIDTH  (CODE_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tile_code),
    .rd_en   (cmd.scan_step),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  logic pend_r, hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      pend_r <= cmd.scan_step;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (pend_r && (rd_data == code_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  // output register
  logic out_valid_r, out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r <= hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  assign sts.empty     = (rgt <= lft) || (bot <= tp);
  assign sts.scan_last = row_end && (cy_r == ey_r);
  assign sts.hit       = hit_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

`ifndef SYNTHESIS
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a word not yet taken");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_init |-> (sx_r <= ex_r) && (sy_r <= ey_r))
    else $error("tile range start beyond its end");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (cx_r <= ex_r) && (cy_r <= ey_r) && (cx_r >= sx_r))
    else $error("tile scan left the tile range");
`endif

endmodule

/* design/tilemap_region_hit_test.sv */
// top level of the tile map region hit test
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    kind, tile_col, tile_row, tile_code, rect_*
//   out      output     out_valid / out_ready  hit
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// one word in flight; in_ready is high only while the sequencer is idle
// write word: goes from accept straight to the finish state, which loads the output register
// query word: clip (an empty region goes on to load), divider (one tile bound per multiply),
//   setup, one tile store read per cycle until a hit or the range ends, then drain if no
//   hit and load
// a full output register stalls the sequencer only when it has a result to load
// synchronous active-low reset; tile store contents are not cleared, cfg is always ready
module tilemap_region_hit_test
  import tmrht_pkg::*;
#(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int TILE_SIZE = DEF_TILE_SIZE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [TCOL_W-1:0]       in_tile_col,
  input  logic [TROW_W-1:0]       in_tile_row,
  input  logic [CODE_W-1:0]       in_tile_code,
  input  logic signed [POS_W-1:0] in_rect_x,
  input  logic signed [POS_W-1:0] in_rect_y,
  input  logic [SIZE_W-1:0]       in_rect_w,
  input  logic [SIZE_W-1:0]       in_rect_h,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_DW-1:0]       cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tmrht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmrht_dp #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .TILE_SIZE (TILE_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_kind      (in_kind),
    .in_tile_col  (in_tile_col),
    .in_tile_row  (in_tile_row),
    .in_tile_code (in_tile_code),
    .in_rect_x    (in_rect_x),
    .in_rect_y    (in_rect_y),
    .in_rect_w    (in_rect_w),
    .in_rect_h    (in_rect_h),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

/* dv/tb_top.sv */
// testbench for the tile map region hit test: directed and random words against a shadow map
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tmrht_pkg::*;

  localparam int COLS_MAX = DEF_MAX_COLS;
  localparam int ROWS_MAX = DEF_MAX_ROWS;
  localparam int TILE     = DEF_TILE_SIZE;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_kind;
  logic [TCOL_W-1:0]       in_tile_col;
  logic [TROW_W-1:0]       in_tile_row;
  logic [CODE_W-1:0]       in_tile_code;
  logic signed [POS_W-1:0] in_rect_x;
  logic signed [POS_W-1:0] in_rect_y;
  logic [SIZE_W-1:0]       in_rect_w;
  logic [SIZE_W-1:0]       in_rect_h;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_hit;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IW-1:0]       cfg_index;
  logic [CFG_DW-1:0]       cfg_wdata;

  logic [CODE_W-1:0] shadow_map [COLS_MAX*ROWS_MAX];
  bit                written    [COLS_MAX*ROWS_MAX];
  logic [CFG_DW-1:0] cols_reg;
  logic [CFG_DW-1:0] rows_reg;
  bit                pending_hits [$];
  int                mismatches;
  bit                gaps_on = 1'b1;
  bit                valid_up;

  tilemap_region_hit_test dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    bit want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t unexpected word: expected none, actual hit %0b", $time, out_hit);
        mismatches++;
      end else begin
        want = pending_hits.pop_front();
        if (out_hit !== want) begin
          $display("%0t hit mismatch: expected %0b, actual %0b", $time, want, out_hit);
          mismatches++;
        end
      end
    end
  end

  function automatic int eff_dim(input logic [CFG_DW-1:0] v, input int limit);
    int d;
    d = int'(v);
    if (d < 1) d = 1;
    if (d > limit) d = limit;
    return d;
  endfunction

  // clip to the map and turn pixels into an inclusive tile range
  function automatic bit tile_span(input logic signed [POS_W-1:0] x, y,
                                   input logic [SIZE_W-1:0] w, h,
                                   output int sx, sy, ex, ey);
    int left, top, right, bottom, wi, hi, mr, mb;
    mr = eff_dim(cols_reg, COLS_MAX) * TILE;
    mb = eff_dim(rows_reg, ROWS_MAX) * TILE;
    wi = int'(w);
    hi = int'(h);
    left = int'(x);
    top = int'(y);
    right = left + wi;
    bottom = top + hi;
    if (left < 0) left = 0;
    if (top < 0) top = 0;
    if (right > mr) right = mr;
    if (bottom > mb) bottom = mb;
    sx = left / TILE;
    sy = top / TILE;
    ex = (right - 1) / TILE;
    ey = (bottom - 1) / TILE;
    return !(right <= left || bottom <= top);
  endfunction

  function automatic bit span_holds_code(input logic signed [POS_W-1:0] x, y,
                                         input logic [SIZE_W-1:0] w, h,
                                         input logic [CODE_W-1:0] code);
    int sx, sy, ex, ey;
    if (!tile_span(x, y, w, h, sx, sy, ex, ey)) return 1'b0;
    for (int r = sy; r <= ey; r++) begin
      for (int c = sx; c <= ex; c++) begin
        if (shadow_map[r*COLS_MAX+c] == code) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic hold_off();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic settle();
    hold_off();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_word(input logic kind, input logic [TCOL_W-1:0] col,
                           input logic [TROW_W-1:0] row, input logic [CODE_W-1:0] code,
                           input logic signed [POS_W-1:0] x, y,
                           input logic [SIZE_W-1:0] w, h, input bit want_hit);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      if (valid_up) in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    pending_hits.insert(pending_hits.size(), want_hit);
    in_kind      <= kind;
    in_tile_col  <= col;
    in_tile_row  <= row;
    in_tile_code <= code;
    in_rect_x    <= x;
    in_rect_y    <= y;
    in_rect_w    <= w;
    in_rect_h    <= h;
    in_valid     <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MAP_COLS) cols_reg = val;
    else rows_reg = val;
    @(posedge clk);
  endtask

  task automatic write_tile(input int col, row, input logic [CODE_W-1:0] code);
    shadow_map[row*COLS_MAX+col] = code;
    written[row*COLS_MAX+col] = 1'b1;
    send_word(KIND_WRITE, TCOL_W'(col), TROW_W'(row), code, POS_W'($urandom()),
              POS_W'($urandom()), SIZE_W'($urandom()), SIZE_W'($urandom()), 1'b0);
  endtask

  // tiles in range that were never written get a code first
  task automatic query_region(input int x, y, w, h, input logic [CODE_W-1:0] code,
                              input bit from_span);
    int sx, sy, ex, ey;
    bit open;
    logic [CODE_W-1:0] probe;
    open = tile_span(POS_W'(x), POS_W'(y), SIZE_W'(w), SIZE_W'(h), sx, sy, ex, ey);
    probe = code;
    if (open) begin
      for (int r = sy; r <= ey; r++) begin
        for (int c = sx; c <= ex; c++) begin
          if (!written[r*COLS_MAX+c]) write_tile(c, r, CODE_W'($urandom_range(0, 15)));
        end
      end
      if (from_span) begin
        probe = shadow_map[$urandom_range(sy, ey)*COLS_MAX + $urandom_range(sx, ex)];
      end
    end
    send_word(KIND_QUERY, TCOL_W'($urandom()), TROW_W'($urandom()), probe,
              POS_W'(x), POS_W'(y), SIZE_W'(w), SIZE_W'(h),
              span_holds_code(POS_W'(x), POS_W'(y), SIZE_W'(w), SIZE_W'(h), probe));
  endtask

  task automatic test_directed();
    write_tile(0, 0, 12'hFFF);
    query_region(0, 0, 1, 1, 12'hFFF, 1'b0);
    query_region(63, 63, 1, 1, 12'hFFF, 1'b0);
    query_region(64, 0, 1, 1, 12'hFFF, 1'b0);
    query_region(-1, -1, 1, 1, 12'hFFF, 1'b0);
    query_region(0, 0, 0, 64, 12'hFFF, 1'b0);
    query_region(0, 0, 64, 0, 12'hFFF, 1'b0);
    query_region(-32768, -32768, 32767, 32767, 12'hFFF, 1'b0);
    query_region(32767, 32767, 32767, 32767, 12'hFFF, 1'b0);
    query_region(-100, -100, 32767, 32767, 12'hFFF, 1'b0);
    query_region(0, 0, 64, 64, 12'h000, 1'b0);
    write_tile(127, 127, 12'h5A5);
    write_tile(127, 0, 12'hA5A);
    write_tile(0, 127, 12'h000);
    write_tile(0, 0, 12'h000);
    query_region(10, 20, 1, 1, 12'h000, 1'b0);
    query_region(-32768, 0, 32767, 1, 12'h000, 1'b0);
  endtask

  task automatic test_register_extremes();
    set_reg(REG_MAP_COLS, 8'd0);
    set_reg(REG_MAP_ROWS, 8'd0);
    query_region(0, 0, 1, 1, 12'h000, 1'b1);
    query_region(64, 0, 1, 1, 12'h000, 1'b0);
    set_reg(REG_MAP_COLS, 8'd255);
    set_reg(REG_MAP_ROWS, 8'd128);
    query_region(8191, 8191, 1, 1, 12'h5A5, 1'b0);
    query_region(8192, 8191, 1, 1, 12'h5A5, 1'b0);
    query_region(8100, 8100, 32767, 32767, 12'h000, 1'b1);
    set_reg(REG_MAP_COLS, 8'd129);
    set_reg(REG_MAP_ROWS, 8'd1);
    query_region(8000, -40, 32767, 200, 12'h000, 1'b1);
  endtask

  task automatic test_full_map();
    set_reg(REG_MAP_COLS, 8'd128);
    set_reg(REG_MAP_ROWS, 8'd128);
    query_region(-1000, -1000, 1064, 1064, 12'hABC, 1'b0);
    query_region(8100, -1, 32767, 65, 12'h000, 1'b1);
    query_region(-1, 8150, 65, 32767, 12'hFFF, 1'b0);
    query_region(8191, 8191, 32767, 32767, 12'h5A5, 1'b0);
  endtask

  task automatic random_phase(input logic [CFG_DW-1:0] cols, rows, input int count);
    int span_c, span_r, x, y, w, h, pick;
    logic [CODE_W-1:0] code;
    set_reg(REG_MAP_COLS, cols);
    set_reg(REG_MAP_ROWS, rows);
    span_c = eff_dim(cols, COLS_MAX);
    span_r = eff_dim(rows, ROWS_MAX);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) settle();
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) code = CODE_W'($urandom());
      else code = CODE_W'($urandom_range(0, 15));
      if (pick < 4) begin
        if ($urandom_range(0, 3) == 0) begin
          write_tile($urandom_range(0, 127), $urandom_range(0, 127), code);
        end else begin
          write_tile($urandom_range(0, span_c - 1), $urandom_range(0, span_r - 1), code);
        end
      end else if (pick < 6) begin
        x = int'($urandom_range(0, span_c * TILE + 63)) - 32;
        y = int'($urandom_range(0, span_r * TILE + 63)) - 32;
        query_region(x, y, 1, 1, code, 1'($urandom_range(0, 1)));
      end else if (pick < 9) begin
        x = int'($urandom_range(0, span_c * TILE + 127)) - 96;
        y = int'($urandom_range(0, span_r * TILE + 127)) - 96;
        w = $urandom_range(0, 160);
        h = $urandom_range(0, 160);
        query_region(x, y, w, h, code, 1'($urandom_range(0, 1)));
      end else begin
        x = $signed(POS_W'($urandom()));
        y = $signed(POS_W'($urandom()));
        w = $urandom_range(0, 32767);
        h = $urandom_range(0, 32767);
        query_region(x, y, w, h, code, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random();
    random_phase(8'd3, 8'd2, 50);
    random_phase(8'd0, 8'd5, 50);
    random_phase(8'd8, 8'd8, 50);
    random_phase(8'd255, 8'd1, 50);
    random_phase(8'd1, 8'd128, 50);
    gaps_on = 1'b0;
    random_phase(8'd7, 8'd9, 50);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_WRITE;
    in_tile_col  = '0;
    in_tile_row  = '0;
    in_tile_code = '0;
    in_rect_x    = '0;
    in_rect_y    = '0;
    in_rect_w    = '0;
    in_rect_h    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_MAP_COLS;
    cfg_wdata    = '0;
    cols_reg     = 8'd1;
    rows_reg     = 8'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_full_map();
    test_random();
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
